### sv/cctt_pkg.sv
package cctt_pkg;

  localparam int CYC_W      = 32;
  localparam int HOST_W     = 64;
  localparam int FREQ_W     = 32;
  localparam int RATIO_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 62;
  localparam int HPROD_W    = HOST_W + RATIO_W;

  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [29:0]          NS_PER_S      = 30'd1000000000;
  localparam logic [FREQ_W-1:0]    FREQ_RST      = 32'd0;
  localparam logic [31:0]          GAP_LIMIT_RST = 32'd200000000;
  localparam logic [RATIO_W-1:0]   RATIO_RST     = 8'd8;
  localparam logic [31:0]          SLACK_RST     = 32'd1000000;

  localparam logic [STATUS_W-1:0]  ST_FIRST  = 2'd0;
  localparam logic [STATUS_W-1:0]  ST_NOFREQ = 2'd1;
  localparam logic [STATUS_W-1:0]  ST_CYCLES = 2'd2;
  localparam logic [STATUS_W-1:0]  ST_GAP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLACK     = 8'd3;

  typedef struct packed {
    logic [CYC_W-1:0]  cycle_sample;
    logic [HOST_W-1:0] host_time_ns;
  } in_t;

  typedef struct packed {
    logic [HOST_W-1:0]   trace_time_ns;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_init;
    logic div_step;
    logic gap_eval;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic fast;
  } sts_t;

endpackage

### sv/cctt_ctrl.sv
module cctt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  input  cctt_pkg::sts_t  sts,
  output cctt_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_GAP   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  localparam logic [cctt_pkg::DIV_CNT_W-1:0] DivLast =
    cctt_pkg::DIV_CNT_W'(cctt_pkg::DIV_STEPS - 1);

  logic [2:0]                     state_r, state_nxt;
  logic [cctt_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.fast ? S_UPD : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DivLast) begin
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        cmd.gap_eval = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && sts.fast) |=> (state_r == S_UPD))
    else $error("fast path did not go straight to update");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == DivLast) |=> (state_r == S_GAP))
    else $error("divider did not finish after its last step");

  a_upd_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && cmd.update) |=> (out_valid_r && state_r == S_IDLE))
    else $error("update did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

endmodule

### sv/cctt_dp.sv
module cctt_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cctt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cctt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  cctt_pkg::in_t                      in_data,
  input  cctt_pkg::cmd_t                     cmd,
  output cctt_pkg::sts_t                     sts,
  output cctt_pkg::out_t                     out_data
);

  logic [cctt_pkg::FREQ_W-1:0]   freq_r;
  logic [31:0]                   gap_limit_r;
  logic [cctt_pkg::RATIO_W-1:0]  ratio_r;
  logic [31:0]                   slack_r;

  logic                          started_r;
  logic [cctt_pkg::CYC_W-1:0]    prev_cyc_r;
  logic [cctt_pkg::HOST_W-1:0]   prev_host_r;
  logic [cctt_pkg::HOST_W-1:0]   accum_r;

  logic [cctt_pkg::CYC_W-1:0]    dcyc_r;
  logic [cctt_pkg::HOST_W-1:0]   dhost_r;
  logic [cctt_pkg::STATUS_W-1:0] status_r;
  logic [cctt_pkg::PROD_W-1:0]   prod_r;
  logic [cctt_pkg::HPROD_W-1:0]  hprod_r;
  logic [cctt_pkg::HOST_W-1:0]   bound_r;
  logic [31:0]                   rem_r;
  logic [cctt_pkg::HOST_W-1:0]   quo_r;
  cctt_pkg::out_t                out_r;

  logic [cctt_pkg::HOST_W-1:0]   hsat;
  logic [cctt_pkg::HOST_W:0]     bsum;
  logic [32:0]                   rem_sh;
  logic                          rem_ge;
  logic                          gap;
  logic [cctt_pkg::HOST_W-1:0]   addend;
  logic [cctt_pkg::HOST_W-1:0]   accum_nxt;

  assign sts.fast = !started_r || (freq_r == '0);
  assign out_data = out_r;

  assign hsat = (|hprod_r[cctt_pkg::HPROD_W-1:cctt_pkg::HOST_W]) ? '1
              : hprod_r[cctt_pkg::HOST_W-1:0];
  assign bsum = {1'b0, hsat} + {33'b0, slack_r};

  assign rem_sh = {rem_r, quo_r[cctt_pkg::HOST_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, freq_r});

  assign gap = (quo_r > {32'b0, gap_limit_r}) ||
               ((dhost_r != '0) && (quo_r > bound_r));

  assign addend = (status_r == cctt_pkg::ST_GAP) ? dhost_r : quo_r;

  always_comb begin
    unique case (status_r)
      cctt_pkg::ST_FIRST:  accum_nxt = '0;
      cctt_pkg::ST_NOFREQ: accum_nxt = accum_r;
      cctt_pkg::ST_CYCLES,
      cctt_pkg::ST_GAP:    accum_nxt = accum_r + addend;
      default:             accum_nxt = accum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= cctt_pkg::FREQ_RST;
      gap_limit_r <= cctt_pkg::GAP_LIMIT_RST;
      ratio_r     <= cctt_pkg::RATIO_RST;
      slack_r     <= cctt_pkg::SLACK_RST;
      started_r   <= 1'b0;
      prev_cyc_r  <= '0;
      prev_host_r <= '0;
      accum_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cctt_pkg::CFG_FREQ:      freq_r      <= cfg_data;
          cctt_pkg::CFG_GAP_LIMIT: gap_limit_r <= cfg_data;
          cctt_pkg::CFG_RATIO:     ratio_r     <= cfg_data[cctt_pkg::RATIO_W-1:0];
          cctt_pkg::CFG_SLACK:     slack_r     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        started_r   <= 1'b1;
        prev_cyc_r  <= in_data.cycle_sample;
        prev_host_r <= in_data.host_time_ns;
      end
      if (cmd.update) begin
        accum_r <= accum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dcyc_r  <= in_data.cycle_sample - prev_cyc_r;
      dhost_r <= in_data.host_time_ns - prev_host_r;
      if (!started_r) begin
        status_r <= cctt_pkg::ST_FIRST;
      end else if (freq_r == '0) begin
        status_r <= cctt_pkg::ST_NOFREQ;
      end else begin
        status_r <= cctt_pkg::ST_CYCLES;
      end
    end
    if (cmd.mul) begin
      prod_r  <= cctt_pkg::PROD_W'(dcyc_r) * cctt_pkg::PROD_W'(cctt_pkg::NS_PER_S);
      hprod_r <= cctt_pkg::HPROD_W'(dhost_r) * cctt_pkg::HPROD_W'(ratio_r);
    end
    if (cmd.div_init) begin
      rem_r   <= '0;
      quo_r   <= cctt_pkg::HOST_W'(prod_r);
      bound_r <= bsum[cctt_pkg::HOST_W] ? '1 : bsum[cctt_pkg::HOST_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? 32'(rem_sh - {1'b0, freq_r}) : rem_sh[31:0];
      quo_r <= {quo_r[cctt_pkg::HOST_W-2:0], rem_ge};
    end
    if (cmd.gap_eval) begin
      status_r <= gap ? cctt_pkg::ST_GAP : cctt_pkg::ST_CYCLES;
    end
    if (cmd.update) begin
      out_r.trace_time_ns <= accum_nxt;
      out_r.status        <= status_r;
    end
  end

endmodule

### sv/cycle_count_to_trace_time.sv
// The first sample or a zero frequency goes from the input transaction straight to update.
// Otherwise: multiply, divider setup, 64 restoring divide steps, gap test, update.
// Input stalls until update, which a stalled pending result holds off; the divider dominates.
// A finished result waits in the output register while the next transaction is taken.
// Reset is synchronous and active low; it clears the trace state and loads register defaults.
module cycle_count_to_trace_time (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cctt_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cctt_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cctt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cctt_pkg::CFG_DATA_W-1:0] cfg_data
);

  cctt_pkg::cmd_t cmd;
  cctt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cctt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  cctt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

### test/cycle_count_to_trace_time_test.sv
module cycle_count_to_trace_time_test;

  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int DRAIN_CYCLES     = 80;
  localparam int NUM_PHASES       = 9;
  localparam int RANDOM_PER_PHASE = 120;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  class trace_time_scoreboard_t;
    logic [31:0]     freq_hz;
    logic [31:0]     gap_limit_ns;
    logic [7:0]      host_ratio;
    logic [31:0]     host_slack_ns;
    bit              started;
    logic [31:0]     prev_cycles;
    logic [63:0]     prev_host_ns;
    logic [63:0]     accum_ns;
    cctt_pkg::out_t  expected_times[$];
    int              errors;

    function new();
      freq_hz       = cctt_pkg::FREQ_RST;
      gap_limit_ns  = cctt_pkg::GAP_LIMIT_RST;
      host_ratio    = cctt_pkg::RATIO_RST;
      host_slack_ns = cctt_pkg::SLACK_RST;
      started       = 1'b0;
      prev_cycles   = '0;
      prev_host_ns  = '0;
      accum_ns      = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [cctt_pkg::CFG_IDX_W-1:0] index,
                            logic [cctt_pkg::CFG_DATA_W-1:0] data);
      case (index)
        cctt_pkg::CFG_FREQ:      freq_hz = data;
        cctt_pkg::CFG_GAP_LIMIT: gap_limit_ns = data;
        cctt_pkg::CFG_RATIO:     host_ratio = data[7:0];
        cctt_pkg::CFG_SLACK:     host_slack_ns = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] host_bound(logic [63:0] dhost);
      logic [71:0] product;
      logic [64:0] total;
      product = 72'(dhost) * 72'(host_ratio);
      if (product[71:64] != 0) product = 72'(64'hFFFF_FFFF_FFFF_FFFF);
      total = 65'(product[63:0]) + 65'(host_slack_ns);
      return total[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total[63:0];
    endfunction

    function void note_sample(cctt_pkg::in_t sample);
      logic [31:0]    dcyc;
      logic [63:0]    cyc_ns;
      logic [63:0]    dhost;
      logic [1:0]     status;
      cctt_pkg::out_t want;
      dcyc  = sample.cycle_sample - prev_cycles;
      dhost = sample.host_time_ns - prev_host_ns;
      if (!started) begin
        started  = 1'b1;
        accum_ns = '0;
        status   = cctt_pkg::ST_FIRST;
      end else if (freq_hz == 0) begin
        status = cctt_pkg::ST_NOFREQ;
      end else begin
        cyc_ns = (64'(dcyc) * 64'(cctt_pkg::NS_PER_S)) / 64'(freq_hz);
        if (cyc_ns > 64'(gap_limit_ns) || (dhost != 0 && cyc_ns > host_bound(dhost))) begin
          accum_ns = accum_ns + dhost;
          status   = cctt_pkg::ST_GAP;
        end else begin
          accum_ns = accum_ns + cyc_ns;
          status   = cctt_pkg::ST_CYCLES;
        end
      end
      prev_cycles  = sample.cycle_sample;
      prev_host_ns = sample.host_time_ns;
      want.trace_time_ns = accum_ns;
      want.status        = status;
      expected_times.push_back(want);
    endfunction

    function void check_result(cctt_pkg::out_t got);
      cctt_pkg::out_t want;
      if (expected_times.size() == 0) begin
        $error("unexpected result: trace_time_ns %0d status %0d", got.trace_time_ns, got.status);
        errors++;
        return;
      end
      want = expected_times.pop_front();
      if (got.trace_time_ns !== want.trace_time_ns) begin
        $error("trace_time_ns expected %0d actual %0d", want.trace_time_ns, got.trace_time_ns);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_times.size();
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  cctt_pkg::in_t                   in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  cctt_pkg::out_t                  out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [cctt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cctt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  trace_time_scoreboard_t sb = new();

  int          idle_cycles = 0;
  int          burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_left  = 0;
  int          stall_tick  = 0;
  logic [31:0] cur_cyc     = '0;
  logic [63:0] cur_host    = '0;
  logic [31:0] phase_freq  = '0;

  cycle_count_to_trace_time i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 400);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
      default:        out_stall <= 1'b0;
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_sample(input logic [31:0] cyc, input logic [63:0] host);
    cctt_pkg::in_t next_item;
    int            gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    next_item.cycle_sample = cyc;
    next_item.host_time_ns = host;
    in_valid <= 1'b1;
    in_data  <= next_item;
    cur_cyc  = cyc;
    cur_host = host;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg_port(input logic [cctt_pkg::CFG_IDX_W-1:0] index,
                                input logic [cctt_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] freq, input logic [31:0] gap_limit,
                               input logic [31:0] ratio, input logic [31:0] slack);
    drain_results();
    write_reg_port(cctt_pkg::CFG_FREQ, freq);
    write_reg_port(cctt_pkg::CFG_GAP_LIMIT, gap_limit);
    write_reg_port(cctt_pkg::CFG_RATIO, ratio);
    write_reg_port(cctt_pkg::CFG_SLACK, slack);
    write_reg_port(cctt_pkg::CFG_IDX_W'($urandom_range(int'(cctt_pkg::CFG_SLACK) + 1, 255)),
                   $urandom);
    phase_freq = freq;
  endtask

  task automatic send_random();
    logic [63:0] span;
    logic [63:0] dcyc;
    logic [63:0] dhost;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      send_sample($urandom, {$urandom, $urandom});
    end else if (kind < 20) begin
      send_sample(cur_cyc + $urandom, cur_host + 64'($urandom_range(0, 1000)));
    end else begin
      case ($urandom_range(0, 3))
        0:       span = 64'($urandom_range(0, 1000));
        1:       span = 64'($urandom_range(0, 1000000));
        2:       span = 64'($urandom_range(0, 250000000));
        default: span = 64'($urandom);
      endcase
      dcyc = (phase_freq == 0) ? 64'($urandom)
           : (span * 64'(phase_freq)) / 64'(cctt_pkg::NS_PER_S);
      case ($urandom_range(0, 5))
        0:       dhost = '0;
        1:       dhost = span >> $urandom_range(1, 12);
        2:       dhost = span * 64'($urandom_range(2, 20));
        default: dhost = span + 64'($urandom_range(0, 1000));
      endcase
      send_sample(cur_cyc + dcyc[31:0], cur_host + dhost);
    end
  endtask

  initial begin
    int phase;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_sample(32'hFFFF_FFF0, 64'hFFFF_FFFF_FFFF_FF00);
    send_sample(32'h0000_0005, 64'd100);

    apply_setting(32'd100_000_000, 32'd200_000_000, 32'd8, 32'd1_000_000);
    send_sample(32'd105, 64'd1100);
    send_sample(32'd1105, 64'd1100);
    send_sample(32'd201105, 64'd1101);
    send_sample(32'd201104, 64'd2_000_000_000);
    send_sample(32'hFFFF_FF00, 64'd3_000_000_000);
    send_sample(32'h0000_0100, 64'd3_000_010_000);
    send_sample(32'h0000_0200, 64'd5);

    // A ratio write with only upper bits set leaves the ratio at zero.
    apply_setting(32'd100_000_000, 32'd200_000_000, 32'h0000_0100, 32'd0);
    send_sample(32'h0000_0300, 64'd10);
    send_sample(32'h0000_0300, 64'd20);

    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255, 32'hFFFF_FFFF);
    send_sample(32'h0000_02FF, 64'd21);
    send_sample(32'h0000_02FF, 64'h8000_0000_0000_0015);
    send_sample(32'h0000_02FE, 64'hFFFF_FFFF_FFFF_FFFF);

    apply_setting(32'd1, 32'hFFFF_FFFF, 32'd1, 32'd0);
    send_sample(32'h0000_02FF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(32'h0000_0304, 64'd100);
    send_sample(32'h0000_0305, 64'd100);
    send_sample(32'h0000_0306, 64'd200);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_setting(32'd100_000_000, 32'd200_000_000, 32'd8, 32'd1_000_000);
        1: apply_setting(32'd1, 32'hFFFF_FFFF, 32'd1, 32'd0);
        2: apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255, 32'hFFFF_FFFF);
        3: apply_setting(32'd0, 32'd200_000_000, 32'd8, 32'd1_000_000);
        4: apply_setting(32'd48_000_000, 32'd0, 32'hFFFF_FF00, 32'd0);
        5: apply_setting(32'd16_000_000, 32'd10_000_000, 32'd2, 32'd500);
        default: apply_setting($urandom, $urandom, $urandom, $urandom);
      endcase
      repeat (RANDOM_PER_PHASE) send_random();
    end

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
